### design/ipv6w_pkg.sv
package ipv6w_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int OFF_W       = OFFSET_BITS;
    localparam int POS_W       = OFFSET_BITS + 1;
    localparam int SUM_W       = ((OFFSET_BITS > 16) ? OFFSET_BITS : 16) + 2;

    typedef logic [OFF_W-1:0] off_t;
    typedef logic [POS_W-1:0] pos_t;
    typedef logic [SUM_W-1:0] sum_t;

    localparam sum_t MAX_OFF = SUM_W'((1 << OFFSET_BITS) - 1);
    localparam pos_t POS_MAX = '1;

    localparam logic [7:0] PROTO_HOPOPT  = 8'd0;
    localparam logic [7:0] PROTO_IPV6    = 8'd41;
    localparam logic [7:0] PROTO_ROUTING = 8'd43;
    localparam logic [7:0] PROTO_FRAG    = 8'd44;
    localparam logic [7:0] PROTO_DSTOPTS = 8'd60;

    localparam int IPV6_HDR_LEN  = 40;
    localparam int EXT_MIN_SPAN  = 2;
    localparam int FRAG_SPAN     = 8;
    localparam int EXT_LEN_SHIFT = 3;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_IP6,
        PH_EXT,
        PH_FRAG,
        PH_DONE,
        PH_FAIL
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TRUNC    = 2'd1,
        ST_NONFIRST = 2'd2
    } status_t;

    typedef struct packed {
        phase_t     phase;
        pos_t       pos;
        off_t       hdr_start;
        logic [7:0] proto;
        off_t       hdr_end;
        status_t    failed;
    } walk_state_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  proto;
        logic [15:0] offset;
    } walk_result_t;

endpackage

### design/ipv6w_step.sv
module ipv6w_step
(
    input  ipv6w_pkg::walk_state_t  cur,
    input  logic [7:0]              data_byte,
    input  logic                    first_byte,
    input  logic                    last_byte,
    input  logic [15:0]             start_offset,
    input  logic [7:0]              start_protocol,
    output ipv6w_pkg::walk_state_t  nxt,
    output logic                    res_valid,
    output ipv6w_pkg::walk_result_t res
);

    function automatic logic is_option_hdr(logic [7:0] p);
        return (p == ipv6w_pkg::PROTO_HOPOPT) || (p == ipv6w_pkg::PROTO_ROUTING) ||
               (p == ipv6w_pkg::PROTO_DSTOPTS);
    endfunction

    function automatic ipv6w_pkg::walk_state_t enter_header(
        ipv6w_pkg::walk_state_t st,
        logic [7:0]             p,
        ipv6w_pkg::off_t        start
    );
        ipv6w_pkg::walk_state_t r;
        ipv6w_pkg::sum_t        span_end;
        logic                   is_hdr;
        r         = st;
        r.hdr_start = start;
        span_end  = '0;
        is_hdr    = 1'b1;
        if (is_option_hdr(p))
        begin
            r.phase  = ipv6w_pkg::PH_EXT;
            span_end = ipv6w_pkg::sum_t'(start) + ipv6w_pkg::sum_t'(ipv6w_pkg::EXT_MIN_SPAN);
        end
        else if (p == ipv6w_pkg::PROTO_FRAG)
        begin
            r.phase  = ipv6w_pkg::PH_FRAG;
            span_end = ipv6w_pkg::sum_t'(start) + ipv6w_pkg::sum_t'(ipv6w_pkg::FRAG_SPAN);
        end
        else
        begin
            r.phase   = ipv6w_pkg::PH_DONE;
            r.proto   = p;
            r.hdr_end = start;
            is_hdr    = 1'b0;
        end
        if (is_hdr)
        begin
            r.failed = ipv6w_pkg::ST_OK;
            if (span_end > ipv6w_pkg::MAX_OFF)
            begin
                r.phase  = ipv6w_pkg::PH_FAIL;
                r.failed = ipv6w_pkg::ST_TRUNC;
            end
            else
            begin
                r.hdr_end = ipv6w_pkg::off_t'(span_end);
            end
        end
        return r;
    endfunction

    ipv6w_pkg::sum_t   soff_w;
    ipv6w_pkg::sum_t   ip6_end;
    ipv6w_pkg::sum_t   ext_end;
    ipv6w_pkg::pos_t   rel;
    logic [ipv6w_pkg::POS_W:0] pos_plus;
    logic              in_hdr;

    assign soff_w   = ipv6w_pkg::sum_t'(start_offset);
    assign ip6_end  = soff_w + ipv6w_pkg::sum_t'(ipv6w_pkg::IPV6_HDR_LEN);
    assign ext_end  = ipv6w_pkg::sum_t'(cur.hdr_start) +
                      ((ipv6w_pkg::sum_t'(data_byte) + ipv6w_pkg::sum_t'(1))
                       << ipv6w_pkg::EXT_LEN_SHIFT);
    assign rel      = cur.pos - ipv6w_pkg::pos_t'(cur.hdr_start);
    assign pos_plus = {1'b0, cur.pos} + (ipv6w_pkg::POS_W + 1)'(1);
    assign in_hdr   = ((cur.phase == ipv6w_pkg::PH_IP6) || (cur.phase == ipv6w_pkg::PH_EXT) ||
                       (cur.phase == ipv6w_pkg::PH_FRAG)) &&
                      (cur.pos >= ipv6w_pkg::pos_t'(cur.hdr_start));

    always_comb
    begin
        nxt       = cur;
        res_valid = 1'b0;
        res       = '{status: ipv6w_pkg::ST_OK, proto: 8'd0, offset: 16'd0};
        if (first_byte)
        begin
            nxt.pos    = ipv6w_pkg::pos_t'(1);
            nxt.failed = ipv6w_pkg::ST_OK;
            nxt.proto  = 8'd0;
            if (soff_w > ipv6w_pkg::MAX_OFF)
            begin
                nxt.hdr_start = '0;
                nxt.hdr_end   = '0;
                nxt.phase     = ipv6w_pkg::PH_FAIL;
                nxt.failed    = ipv6w_pkg::ST_TRUNC;
            end
            else if ((start_offset == 16'd0) || (start_protocol == ipv6w_pkg::PROTO_IPV6))
            begin
                nxt.phase     = ipv6w_pkg::PH_IP6;
                nxt.hdr_start = ipv6w_pkg::off_t'(start_offset);
                if (ip6_end > ipv6w_pkg::MAX_OFF)
                begin
                    nxt.phase  = ipv6w_pkg::PH_FAIL;
                    nxt.failed = ipv6w_pkg::ST_TRUNC;
                end
                else
                begin
                    nxt.hdr_end = ipv6w_pkg::off_t'(ip6_end);
                end
            end
            else
            begin
                nxt = enter_header(nxt, start_protocol, ipv6w_pkg::off_t'(start_offset));
            end
        end
        else if (cur.phase != ipv6w_pkg::PH_IDLE)
        begin
            if (in_hdr)
            begin
                case (cur.phase)
                    ipv6w_pkg::PH_IP6:
                    begin
                        if (rel == ipv6w_pkg::pos_t'(6))
                            nxt.proto = data_byte;
                    end
                    ipv6w_pkg::PH_EXT:
                    begin
                        if (rel == ipv6w_pkg::pos_t'(0))
                            nxt.proto = data_byte;
                        else if (rel == ipv6w_pkg::pos_t'(1))
                        begin
                            if (ext_end > ipv6w_pkg::MAX_OFF)
                            begin
                                nxt.phase  = ipv6w_pkg::PH_FAIL;
                                nxt.failed = ipv6w_pkg::ST_TRUNC;
                            end
                            else
                            begin
                                nxt.hdr_end = ipv6w_pkg::off_t'(ext_end);
                            end
                        end
                    end
                    ipv6w_pkg::PH_FRAG:
                    begin
                        if (rel == ipv6w_pkg::pos_t'(0))
                            nxt.proto = data_byte;
                        else if ((rel == ipv6w_pkg::pos_t'(2)) && (data_byte != 8'd0))
                            nxt.failed = ipv6w_pkg::ST_NONFIRST;
                        else if ((rel == ipv6w_pkg::pos_t'(3)) && (data_byte[7:3] != 5'd0))
                            nxt.failed = ipv6w_pkg::ST_NONFIRST;
                    end
                    default:
                    begin
                    end
                endcase
            end
            // header fully seen: step to the next one in the chain, or fail on a non-first fragment
            if (in_hdr && (nxt.phase != ipv6w_pkg::PH_FAIL) &&
                (pos_plus == (ipv6w_pkg::POS_W + 1)'(nxt.hdr_end)))
            begin
                if ((cur.phase == ipv6w_pkg::PH_FRAG) && (nxt.failed == ipv6w_pkg::ST_NONFIRST))
                begin
                    nxt.phase  = ipv6w_pkg::PH_FAIL;
                    nxt.failed = ipv6w_pkg::ST_NONFIRST;
                end
                else
                begin
                    nxt = enter_header(nxt, nxt.proto, nxt.hdr_end);
                end
            end
            if (cur.pos != ipv6w_pkg::POS_MAX)
                nxt.pos = cur.pos + ipv6w_pkg::pos_t'(1);
        end

        if (last_byte && (first_byte || (cur.phase != ipv6w_pkg::PH_IDLE)))
        begin
            res_valid = 1'b1;
            if (nxt.phase == ipv6w_pkg::PH_DONE)
            begin
                res.status = ipv6w_pkg::ST_OK;
                res.proto  = nxt.proto;
                res.offset = 16'(nxt.hdr_end);
            end
            else if (nxt.phase == ipv6w_pkg::PH_FAIL)
                res.status = nxt.failed;
            else
                res.status = ipv6w_pkg::ST_TRUNC;
            nxt.phase = ipv6w_pkg::PH_IDLE;
        end
    end

endmodule

### design/ipv6_ext_header_walk_top.sv
// IPv6 extension header walker. Packet bytes stream in on the s_ side, one
// beat per byte, first_byte on s_tuser and the final byte on s_tlast; the
// start offset and start protocol ride along in s_tdata and are sampled on
// the first byte only. The walk skips the IPv6 header and hop-by-hop,
// routing, destination options and fragment headers, and on the last byte
// emits one result beat: status on m_tuser (0 found, 1 truncated or offset
// overflow, 2 non-first fragment), upper protocol and upper offset in
// m_tdata (both zero unless found). Throughput is one byte per clock
// while a held result beat does not stall the input: every beat goes
// through a single registered pass of the header-walk logic, with an
// input register in front and a result register behind. Bytes seen
// outside a started packet are dropped without a result.
module ipv6_ext_header_walk_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // data_byte[7:0], start_offset[23:8], start_protocol[31:24]
    input  logic        s_tuser,  // first_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // upper_protocol[7:0], upper_offset[23:8]
    output logic [1:0]  m_tuser   // status
);

    logic        in_valid_reg;
    logic [31:0] in_data_reg;
    logic        in_first_reg;
    logic        in_last_reg;

    ipv6w_pkg::walk_state_t  state_reg;
    ipv6w_pkg::walk_state_t  state_next;
    logic                    res_valid;
    ipv6w_pkg::walk_result_t res;

    logic                    out_valid_reg;
    ipv6w_pkg::walk_result_t out_res_reg;

    logic advance;
    logic fire;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign fire     = in_valid_reg && advance;

    ipv6w_step u_step
    (
        .cur            (state_reg),
        .data_byte      (in_data_reg[7:0]),
        .first_byte     (in_first_reg),
        .last_byte      (in_last_reg),
        .start_offset   (in_data_reg[23:8]),
        .start_protocol (in_data_reg[31:24]),
        .nxt            (state_next),
        .res_valid      (res_valid),
        .res            (res)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg  <= s_tdata;
            in_first_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
    end

    // walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{phase:     ipv6w_pkg::PH_IDLE,
                           pos:       '0,
                           hdr_start: '0,
                           proto:     8'd0,
                           hdr_end:   '0,
                           failed:    ipv6w_pkg::ST_OK};
        end
        else if (fire)
            state_reg <= state_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire && res_valid)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.offset, out_res_reg.proto};
    assign m_tuser  = out_res_reg.status;

endmodule

### tb/sv/ipv6_chain_check.sv
`timescale 1ns / 100ps

module ipv6_chain_check
    import ipv6w_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,  // data_byte[7:0], start_offset[23:8], start_protocol[31:24]
    input  logic        s_tuser,  // first_byte
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,  // upper_protocol[7:0], upper_offset[23:8]
    input  logic [1:0]  m_tuser,  // status
    output int          fail_count,
    output int          due_count
);

    localparam int unsigned LIMIT_OFF = (32'd1 << OFFSET_BITS) - 32'd1;
    localparam int unsigned POS_TOP   = (32'd1 << (OFFSET_BITS + 1)) - 32'd1;

    phase_t      walk_phase = PH_IDLE;
    int unsigned walk_pos   = 0;
    int unsigned hdr_start  = 0;
    int unsigned hdr_end    = 0;
    logic [7:0]  walk_proto = 8'd0;
    status_t     walk_fail  = ST_OK;

    walk_result_t results_due[$];
    int           mismatches = 0;
    int           due_now    = 0;

    assign fail_count = mismatches;
    assign due_count  = due_now;

    task automatic note_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic fail_walk(input status_t code);
        walk_phase = PH_FAIL;
        walk_fail  = code;
    endtask

    task automatic open_header(input logic [7:0] proto, input int unsigned start);
        int unsigned span;
        hdr_start = start;
        if (proto == PROTO_HOPOPT || proto == PROTO_ROUTING || proto == PROTO_DSTOPTS)
        begin
            walk_phase = PH_EXT;
            span       = EXT_MIN_SPAN;
        end
        else if (proto == PROTO_FRAG)
        begin
            walk_phase = PH_FRAG;
            span       = FRAG_SPAN;
        end
        else
        begin
            walk_phase = PH_DONE;
            walk_proto = proto;
            hdr_end    = start;
            return;
        end
        walk_fail = ST_OK;
        if (start + span > LIMIT_OFF)
            fail_walk(ST_TRUNC);
        else
            hdr_end = start + span;
    endtask

    task automatic walk_byte(input logic [7:0] b, input logic first, input logic last,
                             input logic [15:0] soff, input logic [7:0] sproto);
        int unsigned  rel;
        int unsigned  ext_end;
        walk_result_t r;
        if (first)
        begin
            walk_pos   = 0;
            walk_fail  = ST_OK;
            walk_proto = 8'd0;
            if (int'(soff) > LIMIT_OFF)
            begin
                hdr_start = 0;
                hdr_end   = 0;
                fail_walk(ST_TRUNC);
            end
            else if (soff == 16'd0 || sproto == PROTO_IPV6)
            begin
                walk_phase = PH_IP6;
                hdr_start  = int'(soff);
                if (int'(soff) + IPV6_HDR_LEN > LIMIT_OFF)
                    fail_walk(ST_TRUNC);
                else
                    hdr_end = int'(soff) + IPV6_HDR_LEN;
            end
            else
                open_header(sproto, int'(soff));
        end

        if (walk_phase == PH_IDLE)
            return;

        if ((walk_phase == PH_IP6 || walk_phase == PH_EXT || walk_phase == PH_FRAG)
            && walk_pos >= hdr_start)
        begin
            rel = walk_pos - hdr_start;
            case (walk_phase)
                PH_IP6:
                begin
                    if (rel == 6)
                        walk_proto = b;
                end
                PH_EXT:
                begin
                    if (rel == 0)
                        walk_proto = b;
                    else if (rel == 1)
                    begin
                        ext_end = hdr_start + ((int'(b) + 1) << EXT_LEN_SHIFT);
                        if (ext_end > LIMIT_OFF)
                            fail_walk(ST_TRUNC);
                        else
                            hdr_end = ext_end;
                    end
                end
                PH_FRAG:
                begin
                    if (rel == 0)
                        walk_proto = b;
                    else if (rel == 2 && b != 8'd0)
                        walk_fail = ST_NONFIRST;
                    else if (rel == 3 && (b & 8'hF8) != 8'd0)
                        walk_fail = ST_NONFIRST;
                end
                default: ;
            endcase
            if (walk_phase != PH_FAIL && walk_pos + 1 == hdr_end)
            begin
                if (walk_phase == PH_FRAG && walk_fail == ST_NONFIRST)
                    fail_walk(ST_NONFIRST);
                else
                    open_header(walk_proto, hdr_end);
            end
        end

        if (walk_pos < POS_TOP)
            walk_pos = walk_pos + 1;

        if (!last)
            return;

        if (walk_phase == PH_DONE)
        begin
            r.status = ST_OK;
            r.proto  = walk_proto;
            r.offset = 16'(hdr_end);
        end
        else
        begin
            r.status = (walk_phase == PH_FAIL) ? walk_fail : ST_TRUNC;
            r.proto  = 8'd0;
            r.offset = 16'd0;
        end
        results_due.push_back(r);
        walk_phase = PH_IDLE;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        walk_result_t want;
        if (!rst_n)
        begin
            walk_phase = PH_IDLE;
            walk_pos   = 0;
            hdr_start  = 0;
            hdr_end    = 0;
            walk_proto = 8'd0;
            walk_fail  = ST_OK;
            results_due.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                walk_byte(s_tdata[7:0], s_tuser, s_tlast, s_tdata[23:8], s_tdata[31:24]);
            if (m_tvalid && m_tready)
            begin
                if (results_due.size() == 0)
                    note_mismatch($sformatf("result beat with nothing due: status %0d data %h",
                                            m_tuser, m_tdata));
                else
                begin
                    want = results_due.pop_front();
                    if (m_tuser !== want.status)
                        note_mismatch($sformatf("status %0d, want %0d", m_tuser, want.status));
                    if (m_tdata[7:0] !== want.proto)
                        note_mismatch($sformatf("upper protocol %0d, want %0d",
                                                m_tdata[7:0], want.proto));
                    if (m_tdata[23:8] !== want.offset)
                        note_mismatch($sformatf("upper offset %0d, want %0d",
                                                m_tdata[23:8], want.offset));
                end
            end
        end
        due_now = results_due.size();
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import ipv6w_pkg::*;

    localparam int SINK_HOLD = 300;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    int walk_fails;
    int walk_due;

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    bit stall_req    = 1'b0;

    logic [7:0] frame[$];

    ipv6_ext_header_walk_top DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ipv6_chain_check chain_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (walk_fails),
        .due_count  (walk_due)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver: random backpressure, or a long hold when asked
    initial
    begin
        int k;
        forever
        begin
            @(posedge clk);
            if (stall_req)
            begin
                m_tready <= 1'b0;
                for (k = 0; k < SINK_HOLD; k++)
                    @(posedge clk);
                stall_req = 1'b0;
            end
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic first, input logic last,
                             input logic [15:0] soff, input logic [7:0] sproto);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {sproto, soff, b};
        s_tuser  <= first;
        s_tlast  <= last;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
    endtask

    // start fields ride on every beat but only count on the first one
    task automatic send_frame(input logic [15:0] soff, input logic [7:0] sproto,
                              input bit with_last);
        int i;
        for (i = 0; i < frame.size(); i++)
        begin
            if (i == 0)
                send_beat(frame[i], 1'b1, with_last && i == frame.size() - 1, soff, sproto);
            else
                send_beat(frame[i], 1'b0, with_last && i == frame.size() - 1,
                          16'($urandom), 8'($urandom));
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (walk_due != 0);
        @(posedge clk);
    endtask

    task automatic put_rand(input int n);
        int i;
        for (i = 0; i < n; i++)
            frame.push_back(8'($urandom));
    endtask

    task automatic put_ipv6(input logic [7:0] next);
        put_rand(6);
        frame.push_back(next);
        put_rand(33);
    endtask

    task automatic put_ext(input logic [7:0] next, input logic [7:0] len);
        frame.push_back(next);
        frame.push_back(len);
        put_rand((int'(len) + 1) * 8 - 2);
    endtask

    task automatic put_frag(input logic [7:0] next, input logic [7:0] b2, input logic [7:0] b3);
        frame.push_back(next);
        put_rand(1);
        frame.push_back(b2);
        frame.push_back(b3);
        put_rand(4);
    endtask

    function automatic logic [7:0] pick_upper();
        logic [7:0] p;
        do
        begin
            p = 8'($urandom);
        end
        while (p == PROTO_HOPOPT || p == PROTO_ROUTING || p == PROTO_DSTOPTS || p == PROTO_FRAG);
        return p;
    endfunction

    function automatic logic [7:0] pick_ext();
        case ($urandom_range(3))
            0:       return PROTO_HOPOPT;
            1:       return PROTO_ROUTING;
            2:       return PROTO_DSTOPTS;
            default: return PROTO_FRAG;
        endcase
    endfunction

    task automatic put_chain(input logic [7:0] kind, input int depth);
        logic [7:0] cur;
        logic [7:0] nxt;
        int         i;
        cur = kind;
        for (i = 0; i < depth; i++)
        begin
            nxt = (i == depth - 1) ? pick_upper() : pick_ext();
            if (cur != PROTO_FRAG)
                put_ext(nxt, ($urandom_range(99) < 1) ? 8'($urandom) : 8'($urandom_range(2)));
            else if ($urandom_range(99) >= 8)
                put_frag(nxt, 8'd0, 8'($urandom_range(7)));
            else if ($urandom_range(1) == 0)
                put_frag(nxt, 8'($urandom_range(1, 255)), 8'($urandom));
            else
                put_frag(nxt, 8'd0, 8'(($urandom_range(1, 31) << 3) | $urandom_range(7)));
            cur = nxt;
        end
    endtask

    task automatic make_random_frame(output logic [15:0] soff, output logic [7:0] sproto);
        int         depth;
        logic [7:0] kind;
        frame.delete();
        depth = $urandom_range(3);
        kind  = (depth == 0) ? pick_upper() : pick_ext();
        if ($urandom_range(99) < 30)
        begin
            soff   = ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
            sproto = (soff == 16'd0) ? 8'($urandom) : PROTO_IPV6;
            put_rand(int'(soff));
            put_ipv6(kind);
        end
        else
        begin
            soff   = 16'($urandom_range(1, 12));
            sproto = kind;
            put_rand(int'(soff));
        end
        put_chain(kind, depth);
        put_rand($urandom_range(6));
        if ($urandom_range(99) < 15 && frame.size() > 1)
            frame = frame[0:$urandom_range(frame.size() - 2)];
    endtask

    initial
    begin
        logic [15:0] soff;
        logic [7:0]  sproto;
        int          ph;
        int          pick;
        int          n;
        int          phase_bytes;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lone byte: ipv6 at offset zero cut short
        frame = '{8'hFF};
        send_frame(16'd0, 8'd0, 1'b1);
        // upper protocol right at the start offset
        frame = '{8'h00};
        send_frame(16'd5, 8'd6, 1'b1);
        // start offset at the top of the range
        frame = '{8'h00};
        send_frame(16'hFFFF, PROTO_HOPOPT, 1'b1);
        frame = '{8'h80};
        send_frame(16'hFFFF, PROTO_IPV6, 1'b1);
        frame = '{8'h01};
        send_frame(16'hFFFF, 8'hFF, 1'b1);
        frame = '{8'h7F};
        send_frame(16'hFFFE, PROTO_FRAG, 1'b1);
        // bare ipv6 header, then one with 41 as upper protocol
        frame.delete();
        put_ipv6(8'd6);
        send_frame(16'd0, 8'hFF, 1'b1);
        frame.delete();
        put_ipv6(PROTO_IPV6);
        send_frame(16'd0, 8'd0, 1'b1);
        // routing header with the largest length, cut short
        frame.delete();
        put_rand(1);
        frame.push_back(8'd17);
        frame.push_back(8'hFF);
        put_rand(4);
        send_frame(16'd1, PROTO_ROUTING, 1'b1);
        // non-first fragments, offset in either byte
        frame.delete();
        put_rand(2);
        put_frag(8'd17, 8'd1, 8'd0);
        send_frame(16'd2, PROTO_FRAG, 1'b1);
        frame.delete();
        put_rand(2);
        put_frag(8'd6, 8'd0, 8'h08);
        send_frame(16'd2, PROTO_FRAG, 1'b1);
        // first fragment with flag bits set
        frame.delete();
        put_rand(2);
        put_frag(8'd6, 8'd0, 8'h07);
        send_frame(16'd2, PROTO_FRAG, 1'b1);
        // non-first fragment that never fully arrives
        frame.delete();
        put_rand(2);
        put_frag(8'd6, 8'h80, 8'd0);
        frame = frame[0:6];
        send_frame(16'd2, PROTO_FRAG, 1'b1);
        // bytes outside any packet
        send_beat(8'hAA, 1'b0, 1'b0, 16'hFFFF, 8'hFF);
        send_beat(8'h55, 1'b0, 1'b1, 16'h0000, 8'h00);
        // first byte in the middle of a packet
        frame.delete();
        put_ipv6(8'd6);
        frame = frame[0:9];
        send_frame(16'd0, 8'd0, 1'b0);
        frame = '{8'h33};
        send_frame(16'd3, 8'd58, 1'b1);
        // every extension kind on one chain
        frame.delete();
        put_ipv6(PROTO_HOPOPT);
        put_ext(PROTO_ROUTING, 8'd0);
        put_ext(PROTO_DSTOPTS, 8'd1);
        put_ext(PROTO_FRAG, 8'd0);
        put_frag(8'd17, 8'd0, 8'd0);
        put_rand(4);
        send_frame(16'd0, 8'd0, 1'b1);
        wait_drained();

        for (ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    src_idle_pct = 17;
                    snk_idle_pct = 75;
                end
                1:
                begin
                    src_idle_pct = 75;
                    snk_idle_pct = 17;
                end
                default:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase

            if (ph == 2)
            begin
                // hold the result side while short packets keep coming
                stall_req = 1'b1;
                repeat (12)
                begin
                    frame = '{8'($urandom)};
                    send_frame(16'($urandom_range(1, 65535)), pick_upper(), 1'b1);
                end
                wait_drained();
            end

            phase_bytes = 0;
            while (phase_bytes < 180)
            begin
                pick = $urandom_range(99);
                if (pick < 5)
                begin
                    n = $urandom_range(1, 4);
                    repeat (n)
                        send_beat(8'($urandom), 1'b0, 1'($urandom), 16'($urandom),
                                  8'($urandom));
                    phase_bytes += n;
                end
                else if (pick < 15)
                begin
                    frame.delete();
                    put_rand($urandom_range(1, 6));
                    send_frame(16'($urandom), 8'($urandom), 1'b1);
                    phase_bytes += frame.size();
                end
                else
                begin
                    make_random_frame(soff, sproto);
                    if (pick < 21 && frame.size() > 1)
                    begin
                        frame = frame[0:$urandom_range(frame.size() - 2)];
                        send_frame(soff, sproto, 1'b0);
                    end
                    else
                    begin
                        send_frame(soff, sproto, 1'b1);
                    end
                    phase_bytes += frame.size();
                end
            end
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (walk_fails == 0 && walk_due == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
